// ===== rtl/chs_pkg.sv =====
// shared constants, stage record type and step functions for the hemisphere sampler
package chs_pkg;

  localparam int FracBits    = 14;
  localparam int RandBits    = 16;
  localparam int CordicSteps = 30;
  localparam int SqrtSteps   = 16;
  localparam int DivSteps    = 15;

  // stage numbers of the pipeline
  localparam int StRandSqrt  = 2;                          // first step of r and z roots
  localparam int StNormSum   = 2;
  localparam int StNormSqrt  = 3;                          // first step of len and sin roots
  localparam int StCordic    = 2;                          // first micro-rotation
  localparam int StCosSin    = StCordic + CordicSteps;     // 32
  localparam int StDiskMul   = StCosSin + 1;               // 33
  localparam int StDiskRnd   = StDiskMul + 1;              // 34
  localparam int StDivInit   = StNormSqrt + SqrtSteps;     // 19
  localparam int StDivStep   = StDivInit + 1;              // 20
  localparam int StAxis      = StDivStep + DivSteps;       // 35
  localparam int StCrossMul  = StAxis + 1;                 // 36
  localparam int StCrossRnd  = StCrossMul + 1;             // 37
  localparam int StTermMul   = StCrossRnd + 1;             // 38
  localparam int StKdRnd     = StTermMul + 1;              // 39
  localparam int StKdMul     = StKdRnd + 1;                // 40
  localparam int StSum       = StKdMul + 1;                // 41
  localparam int Depth       = StSum;

  localparam logic signed [33:0] CordicGain = 34'sh026DD3B6A;
  localparam logic signed [39:0] One        = 40'sd16384;
  localparam logic [30:0]        OneSq      = 31'h1000_0000;

  localparam logic [1:0] QuadFirst  = 2'd0;
  localparam logic [1:0] QuadSecond = 2'd1;
  localparam logic [1:0] QuadThird  = 2'd2;
  localparam logic [1:0] QuadFourth = 2'd3;

  typedef struct packed {
    logic [15:0] root;
    logic [19:0] rem;
  } sqrt_t;

  typedef struct packed {
    logic [15:0] rem;
    logic [14:0] quo;
  } div_t;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [1:0]         quad;
    logic [30:0]        nx2;
    logic [30:0]        ny2;
    logic [30:0]        nz2;
    logic [31:0]        rr_n;
    logic [31:0]        rz_n;
    logic [31:0]        sl_n;
    logic [31:0]        ss_n;
    sqrt_t              rr;
    sqrt_t              rz;
    sqrt_t              sl;
    sqrt_t              ss;
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    logic signed [32:0] cz;
    logic signed [17:0] c;
    logic signed [17:0] s;
    logic signed [35:0] pv0;
    logic signed [35:0] pv1;
    logic signed [17:0] v0;
    logic signed [17:0] v1;
    logic [29:0]        numx;
    logic [29:0]        numy;
    div_t               dvx;
    div_t               dvy;
    logic signed [16:0] ax;
    logic signed [16:0] ay;
    logic signed [35:0] p_ayv2;
    logic signed [35:0] p_axv2;
    logic signed [35:0] p_axv1;
    logic signed [35:0] p_ayv0;
    logic signed [35:0] p_axv0;
    logic signed [35:0] p_ayv1;
    logic signed [19:0] cr0;
    logic signed [19:0] cr1;
    logic signed [19:0] cr2;
    logic signed [19:0] dot;
    logic signed [39:0] kp0;
    logic signed [39:0] kp1;
    logic signed [19:0] kd0;
    logic signed [19:0] kd1;
    logic signed [17:0] omz;
    logic signed [39:0] tv0;
    logic signed [39:0] tv1;
    logic signed [39:0] tv2;
    logic signed [39:0] ts0;
    logic signed [39:0] ts1;
    logic signed [39:0] ts2;
    logic signed [39:0] tk0;
    logic signed [39:0] tk1;
    logic signed [15:0] dir0;
    logic signed [15:0] dir1;
    logic signed [15:0] dir2;
  } stage_t;

  // atan(2^-i) in units of 2^32 per turn
  function automatic logic [29:0] atan_lut(input int i);
    logic [29:0] a;
    case (i)
      0:  a = 30'h20000000;
      1:  a = 30'h12E4051E;
      2:  a = 30'h09FB385B;
      3:  a = 30'h051111D4;
      4:  a = 30'h028B0D43;
      5:  a = 30'h0145D7E1;
      6:  a = 30'h00A2F61E;
      7:  a = 30'h00517C55;
      8:  a = 30'h0028BE53;
      9:  a = 30'h00145F2F;
      10: a = 30'h000A2F98;
      11: a = 30'h000517CC;
      12: a = 30'h00028BE6;
      13: a = 30'h000145F3;
      14: a = 30'h0000A2F9;
      15: a = 30'h0000517C;
      16: a = 30'h000028BE;
      17: a = 30'h0000145F;
      18: a = 30'h00000A2F;
      19: a = 30'h00000517;
      20: a = 30'h0000028B;
      21: a = 30'h00000145;
      22: a = 30'h000000A2;
      23: a = 30'h00000051;
      24: a = 30'h00000028;
      25: a = 30'h00000014;
      26: a = 30'h0000000A;
      27: a = 30'h00000005;
      28: a = 30'h00000002;
      29: a = 30'h00000001;
      default: a = '0;
    endcase
    return a;
  endfunction

  // one result bit of a floor square root, two radicand bits consumed
  function automatic sqrt_t sqrt_step(input logic [31:0] n, input sqrt_t cur, input int j);
    logic [19:0] rem_t;
    logic [19:0] trial;
    sqrt_t       res;
    rem_t = {cur.rem[17:0], n[31-2*j -: 2]};
    trial = {2'b00, cur.root, 2'b01};
    if (rem_t >= trial) begin
      res.rem  = rem_t - trial;
      res.root = {cur.root[14:0], 1'b1};
    end else begin
      res.rem  = rem_t;
      res.root = {cur.root[14:0], 1'b0};
    end
    return res;
  endfunction

  // one quotient bit of a restoring division
  function automatic div_t div_step(input logic [15:0] d, input logic b, input div_t cur);
    logic [16:0] rem_t;
    div_t        res;
    rem_t = {cur.rem, b};
    if (rem_t >= {1'b0, d}) begin
      res.rem = 16'(rem_t - {1'b0, d});
      res.quo = {cur.quo[13:0], 1'b1};
    end else begin
      res.rem = rem_t[15:0];
      res.quo = {cur.quo[13:0], 1'b0};
    end
    return res;
  endfunction

  // round half up by FracBits
  function automatic logic signed [39:0] rnd_frac(input logic signed [39:0] v);
    return (v + 40'sd8192) >>> FracBits;
  endfunction

endpackage

// ===== rtl/cosine_hemisphere_sampler.sv =====
// cosine-weighted hemisphere direction sampler, fully pipelined
//
// input channel: in_valid_i / in_stall_o with a unit normal (signed q1.14)
// and two uniform fractions (unsigned 0.16); an item is taken at a clock
// edge with in_valid_i high and in_stall_o low
// output channel: out_valid_o / out_stall_i with the direction (signed q1.14,
// saturated to +-1.0)
// depth: 41 register stages, the last of which drives out_valid_o; the
// depth is set by the chain normal squares -> 16-step root of the normal
// length -> 15-step axis division -> rotation products; the 30-step
// cordic and the disk roots run alongside
// throughput: one item per cycle unless stalled; each stage holds one item
// with its valid bit, and every stage advances together
// stall: when the output register holds an item that is stalled, the whole
// pipeline holds and in_stall_o rises; nothing is dropped or repeated
// reset: clears every valid bit; payload registers are not reset
// the exact +z and -z normals need no bypass: with a zero axis the rotation
// reduces to v*nz, which gives v and -v exactly
module cosine_hemisphere_sampler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] normal_x_i,
  input  logic [15:0] normal_y_i,
  input  logic [15:0] normal_z_i,
  input  logic [15:0] rand_radius_i,
  input  logic [15:0] rand_angle_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] dir_x_o,
  output logic [15:0] dir_y_o,
  output logic [15:0] dir_z_o
);

  chs_pkg::stage_t st_q [1:chs_pkg::Depth];
  chs_pkg::stage_t st_d [1:chs_pkg::Depth];
  logic [chs_pkg::Depth:1] vld_q;
  logic [chs_pkg::Depth:1] vld_d;
  logic adv;

  // the pipeline moves whenever the output slot is free or being taken
  assign adv        = !vld_q[chs_pkg::Depth] || !out_stall_i;
  assign in_stall_o = !adv;
  assign vld_d      = {vld_q[chs_pkg::Depth-1:1], in_valid_i};

  always_comb begin
    chs_pkg::stage_t    cur;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [39:0] ta;
    logic signed [39:0] tb;
    logic signed [39:0] rc;
    logic signed [39:0] rs;
    logic signed [39:0] sum;
    logic signed [17:0] v2s;
    logic signed [17:0] sinas;
    logic signed [16:0] mx;
    logic signed [16:0] my;
    logic [15:0]        absx;
    logic [15:0]        absy;
    logic [16:0]        zdiff;

    dx    = '0;
    dy    = '0;
    ta    = '0;
    tb    = '0;
    rc    = '0;
    rs    = '0;
    sum   = '0;
    v2s   = '0;
    sinas = '0;
    mx    = '0;
    my    = '0;
    absx  = '0;
    absy  = '0;

    // first stage: squares of the normal, root and cordic seeds
    cur      = '0;
    cur.nx   = $signed(normal_x_i);
    cur.ny   = $signed(normal_y_i);
    cur.nz   = $signed(normal_z_i);
    cur.nx2  = 31'(32'($signed(normal_x_i)) * 32'($signed(normal_x_i)));
    cur.ny2  = 31'(32'($signed(normal_y_i)) * 32'($signed(normal_y_i)));
    cur.nz2  = 31'(32'($signed(normal_z_i)) * 32'($signed(normal_z_i)));
    cur.quad = rand_angle_i[15:14];
    zdiff    = 17'h10000 - {1'b0, rand_radius_i};
    cur.rr_n = {4'b0, rand_radius_i, 12'b0};
    cur.rz_n = {3'b0, zdiff, 12'b0};
    cur.cx   = chs_pkg::CordicGain;
    cur.cy   = '0;
    cur.cz   = $signed({3'b000, rand_angle_i[13:0], 16'b0});
    st_d[1]  = cur;

    for (int k = 2; k <= chs_pkg::Depth; k++) begin
      cur = st_q[k-1];

      // radius and height roots of the disk point
      if (k >= chs_pkg::StRandSqrt && k < chs_pkg::StRandSqrt + chs_pkg::SqrtSteps) begin
        cur.rr = chs_pkg::sqrt_step(st_q[k-1].rr_n, st_q[k-1].rr, k - chs_pkg::StRandSqrt);
        cur.rz = chs_pkg::sqrt_step(st_q[k-1].rz_n, st_q[k-1].rz, k - chs_pkg::StRandSqrt);
      end

      // radicands for the axis length and sin of the tilt
      if (k == chs_pkg::StNormSum) begin
        cur.sl_n = {1'b0, st_q[k-1].nx2} + {1'b0, st_q[k-1].ny2};
        if (st_q[k-1].nz2 < chs_pkg::OneSq) begin
          cur.ss_n = {1'b0, chs_pkg::OneSq - st_q[k-1].nz2};
        end else begin
          cur.ss_n = '0;
        end
      end

      if (k >= chs_pkg::StNormSqrt && k < chs_pkg::StNormSqrt + chs_pkg::SqrtSteps) begin
        cur.sl = chs_pkg::sqrt_step(st_q[k-1].sl_n, st_q[k-1].sl, k - chs_pkg::StNormSqrt);
        cur.ss = chs_pkg::sqrt_step(st_q[k-1].ss_n, st_q[k-1].ss, k - chs_pkg::StNormSqrt);
      end

      // cordic micro-rotation
      if (k >= chs_pkg::StCordic && k < chs_pkg::StCosSin) begin
        dx = st_q[k-1].cy >>> (k - chs_pkg::StCordic);
        dy = st_q[k-1].cx >>> (k - chs_pkg::StCordic);
        if (st_q[k-1].cz >= 0) begin
          cur.cx = st_q[k-1].cx - dx;
          cur.cy = st_q[k-1].cy + dy;
          cur.cz = st_q[k-1].cz - $signed({3'b000, chs_pkg::atan_lut(k - chs_pkg::StCordic)});
        end else begin
          cur.cx = st_q[k-1].cx + dx;
          cur.cy = st_q[k-1].cy - dy;
          cur.cz = st_q[k-1].cz + $signed({3'b000, chs_pkg::atan_lut(k - chs_pkg::StCordic)});
        end
      end

      // round to q14 and unfold the quadrant
      if (k == chs_pkg::StCosSin) begin
        rc = 40'((st_q[k-1].cx + 34'sd32768) >>> 16);
        rs = 40'((st_q[k-1].cy + 34'sd32768) >>> 16);
        case (st_q[k-1].quad)
          chs_pkg::QuadFirst: begin
            cur.c = 18'(rc);
            cur.s = 18'(rs);
          end
          chs_pkg::QuadSecond: begin
            cur.c = 18'(-rs);
            cur.s = 18'(rc);
          end
          chs_pkg::QuadThird: begin
            cur.c = 18'(-rc);
            cur.s = 18'(-rs);
          end
          default: begin
            cur.c = 18'(rs);
            cur.s = 18'(-rc);
          end
        endcase
      end

      if (k == chs_pkg::StDiskMul) begin
        cur.pv0 = $signed({2'b00, st_q[k-1].rr.root}) * st_q[k-1].c;
        cur.pv1 = $signed({2'b00, st_q[k-1].rr.root}) * st_q[k-1].s;
      end

      if (k == chs_pkg::StDiskRnd) begin
        cur.v0 = 18'(chs_pkg::rnd_frac(40'(st_q[k-1].pv0)));
        cur.v1 = 18'(chs_pkg::rnd_frac(40'(st_q[k-1].pv1)));
      end

      // rounded numerators |n|*one + len/2; the quotient stays below 2^15
      if (k == chs_pkg::StDivInit) begin
        absx = st_q[k-1].nx[15] ? 16'(~st_q[k-1].nx + 16'sd1) : st_q[k-1].nx;
        absy = st_q[k-1].ny[15] ? 16'(~st_q[k-1].ny + 16'sd1) : st_q[k-1].ny;
        cur.numx    = {absx, 14'b0} + {15'b0, st_q[k-1].sl.root[15:1]};
        cur.numy    = {absy, 14'b0} + {15'b0, st_q[k-1].sl.root[15:1]};
        cur.dvx.rem = {1'b0, cur.numx[29:15]};
        cur.dvy.rem = {1'b0, cur.numy[29:15]};
        cur.dvx.quo = '0;
        cur.dvy.quo = '0;
      end

      if (k >= chs_pkg::StDivStep && k < chs_pkg::StAxis) begin
        cur.dvx = chs_pkg::div_step(st_q[k-1].sl.root,
                    st_q[k-1].numx[chs_pkg::StAxis - 1 - k], st_q[k-1].dvx);
        cur.dvy = chs_pkg::div_step(st_q[k-1].sl.root,
                    st_q[k-1].numy[chs_pkg::StAxis - 1 - k], st_q[k-1].dvy);
      end

      // axis (-ny, nx, 0) / len, zero when the normal has no xy part
      if (k == chs_pkg::StAxis) begin
        mx = $signed({2'b00, st_q[k-1].dvx.quo});
        my = $signed({2'b00, st_q[k-1].dvy.quo});
        if (st_q[k-1].sl.root == '0) begin
          cur.ax = '0;
          cur.ay = '0;
        end else begin
          cur.ax = st_q[k-1].ny[15] ? my : -my;
          cur.ay = st_q[k-1].nx[15] ? -mx : mx;
        end
      end

      if (k == chs_pkg::StCrossMul) begin
        v2s        = $signed({2'b00, st_q[k-1].rz.root});
        cur.p_ayv2 = st_q[k-1].ay * v2s;
        cur.p_axv2 = st_q[k-1].ax * v2s;
        cur.p_axv1 = st_q[k-1].ax * st_q[k-1].v1;
        cur.p_ayv0 = st_q[k-1].ay * st_q[k-1].v0;
        cur.p_axv0 = st_q[k-1].ax * st_q[k-1].v0;
        cur.p_ayv1 = st_q[k-1].ay * st_q[k-1].v1;
      end

      // cross product k x v and dot product k.v
      if (k == chs_pkg::StCrossRnd) begin
        cur.cr0 = 20'(chs_pkg::rnd_frac(40'(st_q[k-1].p_ayv2)));
        ta      = 40'(st_q[k-1].p_axv2);
        cur.cr1 = 20'(chs_pkg::rnd_frac(-ta));
        ta      = 40'(st_q[k-1].p_axv1);
        tb      = 40'(st_q[k-1].p_ayv0);
        cur.cr2 = 20'(chs_pkg::rnd_frac(ta - tb));
        ta      = 40'(st_q[k-1].p_axv0);
        tb      = 40'(st_q[k-1].p_ayv1);
        cur.dot = 20'(chs_pkg::rnd_frac(ta + tb));
      end

      if (k == chs_pkg::StTermMul) begin
        v2s     = $signed({2'b00, st_q[k-1].rz.root});
        sinas   = $signed({2'b00, st_q[k-1].ss.root});
        cur.kp0 = st_q[k-1].ax * st_q[k-1].dot;
        cur.kp1 = st_q[k-1].ay * st_q[k-1].dot;
        cur.tv0 = st_q[k-1].v0 * st_q[k-1].nz;
        cur.tv1 = st_q[k-1].v1 * st_q[k-1].nz;
        cur.tv2 = v2s * st_q[k-1].nz;
        cur.ts0 = st_q[k-1].cr0 * sinas;
        cur.ts1 = st_q[k-1].cr1 * sinas;
        cur.ts2 = st_q[k-1].cr2 * sinas;
      end

      if (k == chs_pkg::StKdRnd) begin
        cur.kd0 = 20'(chs_pkg::rnd_frac(st_q[k-1].kp0));
        cur.kd1 = 20'(chs_pkg::rnd_frac(st_q[k-1].kp1));
        cur.omz = 18'(chs_pkg::One - 40'(st_q[k-1].nz));
      end

      if (k == chs_pkg::StKdMul) begin
        cur.tk0 = st_q[k-1].kd0 * st_q[k-1].omz;
        cur.tk1 = st_q[k-1].kd1 * st_q[k-1].omz;
      end

      // sum the three rodrigues terms, round once and saturate
      if (k == chs_pkg::StSum) begin
        sum = chs_pkg::rnd_frac(st_q[k-1].tv0 + st_q[k-1].ts0 + st_q[k-1].tk0);
        if (sum > chs_pkg::One) begin
          cur.dir0 = 16'(chs_pkg::One);
        end else if (sum < -chs_pkg::One) begin
          cur.dir0 = 16'(-chs_pkg::One);
        end else begin
          cur.dir0 = 16'(sum);
        end
        sum = chs_pkg::rnd_frac(st_q[k-1].tv1 + st_q[k-1].ts1 + st_q[k-1].tk1);
        if (sum > chs_pkg::One) begin
          cur.dir1 = 16'(chs_pkg::One);
        end else if (sum < -chs_pkg::One) begin
          cur.dir1 = 16'(-chs_pkg::One);
        end else begin
          cur.dir1 = 16'(sum);
        end
        sum = chs_pkg::rnd_frac(st_q[k-1].tv2 + st_q[k-1].ts2);
        if (sum > chs_pkg::One) begin
          cur.dir2 = 16'(chs_pkg::One);
        end else if (sum < -chs_pkg::One) begin
          cur.dir2 = 16'(-chs_pkg::One);
        end else begin
          cur.dir2 = 16'(sum);
        end
      end

      st_d[k] = cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q <= st_d;
    end
  end

  assign out_valid_o = vld_q[chs_pkg::Depth];
  assign dir_x_o     = st_q[chs_pkg::Depth].dir0;
  assign dir_y_o     = st_q[chs_pkg::Depth].dir1;
  assign dir_z_o     = st_q[chs_pkg::Depth].dir2;

endmodule

// ===== tb/tb_cosine_hemisphere_sampler.sv =====
// self-checking testbench for the cosine-weighted hemisphere sampler
module tb_cosine_hemisphere_sampler;

  localparam int NumRandom = 1100;
  localparam int Latency   = chs_pkg::Depth;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] normal_x_i = '0;
  logic [15:0] normal_y_i = '0;
  logic [15:0] normal_z_i = '0;
  logic [15:0] rand_radius_i = '0;
  logic [15:0] rand_angle_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] dir_x_o;
  logic [15:0] dir_y_o;
  logic [15:0] dir_z_o;

  typedef struct packed {
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic [15:0] u1;
    logic [15:0] u2;
  } sample_req_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
  } dir_t;

  // directed row: request plus an optional typed-in direction
  typedef struct packed {
    sample_req_t req;
    logic        known;
    dir_t        dir;
  } row_t;

  dir_t        pending_dirs[$];
  int          failures = 0;
  logic        stim_done = 1'b0;

  cosine_hemisphere_sampler u_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint floor_sqrt(input longint unsigned n);
    longint unsigned acc, bitv;
    acc = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= acc + bitv) begin
        n -= acc + bitv;
        acc = (acc >> 1) + bitv;
      end else begin
        acc >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(acc);
  endfunction

  // round half up by s bits; >>> on signed longint floors
  function automatic longint round_shift(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint atan_step(input int i);
    longint tbl[30];
    tbl = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
            64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
            64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
            64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
            64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
            64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001};
    return tbl[i];
  endfunction

  function automatic logic [15:0] clamp_unit(input longint v);
    longint o;
    o = longint'(1) <<< chs_pkg::FracBits;
    if (v > o) v = o;
    if (v < -o) v = -o;
    return v[15:0];
  endfunction

  function automatic dir_t predict_dir(input sample_req_t q);
    longint one, nx, ny, nz, u1, u2, r, v0, v1, v2, cx, cy, ang, dx, dy, cc, ss, c, s;
    longint len, ax, ay, sina, cr0, cr1, cr2, dotp, kd0, kd1, rx, ry, rz;
    int fb;
    logic [1:0] quad;
    dir_t d;
    fb = chs_pkg::FracBits;
    one = longint'(1) <<< fb;
    nx = longint'($signed(q.nx));
    ny = longint'($signed(q.ny));
    nz = longint'($signed(q.nz));
    u1 = longint'(q.u1);
    u2 = longint'(q.u2);
    // disk radius and lifted height, fractions rescaled to q2.28
    r  = floor_sqrt(u1 <<< (2 * fb - chs_pkg::RandBits));
    v2 = floor_sqrt((65536 - u1) <<< (2 * fb - chs_pkg::RandBits));
    // cordic on the angle below one quadrant, then quadrant fold
    quad = q.u2[15:14];
    ang = (u2 <<< 16) & 64'h3FFFFFFF;
    cx = 64'h26DD3B6A;
    cy = 0;
    for (int i = 0; i < chs_pkg::CordicSteps; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (ang >= 0) begin
        cx -= dx; cy += dy; ang -= atan_step(i);
      end else begin
        cx += dx; cy -= dy; ang += atan_step(i);
      end
    end
    cc = round_shift(cx, 30 - fb);
    ss = round_shift(cy, 30 - fb);
    case (quad)
      chs_pkg::QuadFirst:  begin c = cc;  s = ss;  end
      chs_pkg::QuadSecond: begin c = -ss; s = cc;  end
      chs_pkg::QuadThird:  begin c = -cc; s = -ss; end
      default:             begin c = ss;  s = -cc; end
    endcase
    v0 = round_shift(r * c, fb);
    v1 = round_shift(r * s, fb);
    if (nx == 0 && ny == 0 && nz == one) begin
      rx = v0; ry = v1; rz = v2;
    end else if (nx == 0 && ny == 0 && nz == -one) begin
      rx = -v0; ry = -v1; rz = -v2;
    end else begin
      ax = 0;
      ay = 0;
      len = floor_sqrt(nx * nx + ny * ny);
      if (len != 0) begin
        ax = ((ny < 0 ? -ny : ny) * one + len / 2) / len;
        ay = ((nx < 0 ? -nx : nx) * one + len / 2) / len;
        if (ny >= 0) ax = -ax;
        if (nx < 0) ay = -ay;
      end
      sina = (one * one > nz * nz) ? floor_sqrt(one * one - nz * nz) : 0;
      cr0  = round_shift(ay * v2, fb);
      cr1  = round_shift(-ax * v2, fb);
      cr2  = round_shift(ax * v1 - ay * v0, fb);
      dotp = round_shift(ax * v0 + ay * v1, fb);
      kd0  = round_shift(ax * dotp, fb);
      kd1  = round_shift(ay * dotp, fb);
      rx = round_shift(v0 * nz + cr0 * sina + kd0 * (one - nz), fb);
      ry = round_shift(v1 * nz + cr1 * sina + kd1 * (one - nz), fb);
      rz = round_shift(v2 * nz + cr2 * sina, fb);
    end
    d.x = clamp_unit(rx);
    d.y = clamp_unit(ry);
    d.z = clamp_unit(rz);
    return d;
  endfunction

  // ---------------------------------------------------------------- sender

  task automatic send_sample(input sample_req_t q, input logic known, input dir_t dir);
    dir_t want;
    want = known ? dir : predict_dir(q);
    in_valid_i    <= 1'b1;
    normal_x_i    <= q.nx;
    normal_y_i    <= q.ny;
    normal_z_i    <= q.nz;
    rand_radius_i <= q.u1;
    rand_angle_i  <= q.u2;
    // wait for the accepting edge
    do @(posedge clk_i); while (in_stall_o);
    pending_dirs.push_back(want);
    @(negedge clk_i);
  endtask

  task automatic idle_cycles(input int n);
    in_valid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'h4000;
      1: return 16'hC000;
      2: return 16'h0000;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // mostly unit-length normals, some arbitrary vectors in range
  function automatic sample_req_t rand_req();
    sample_req_t q;
    int sel;
    real th, ph;
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      th = $urandom_range(0, 100000) / 100000.0 * 3.14159265;
      ph = $urandom_range(0, 100000) / 100000.0 * 6.28318531;
      q.nx = 16'($rtoi($sin(th) * $cos(ph) * 16384.0));
      q.ny = 16'($rtoi($sin(th) * $sin(ph) * 16384.0));
      q.nz = 16'($rtoi($cos(th) * 16384.0));
    end else if (sel == 7) begin
      q.nx = '0;
      q.ny = '0;
      q.nz = ($urandom_range(0, 1) != 0) ? 16'h4000 : 16'hC000;
    end else begin
      q.nx = rand_comp();
      q.ny = rand_comp();
      q.nz = rand_comp();
    end
    q.u1 = 16'($urandom_range(0, 65535));
    q.u2 = 16'($urandom_range(0, 65535));
    return q;
  endfunction

  row_t directed[] = '{
    // straight up, zero fractions: pole of the hemisphere
    '{'{16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000}, 1'b1,
      '{16'h0000, 16'h0000, 16'h4000}},
    // straight down negates the sample
    '{'{16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h0000}, 1'b1,
      '{16'h0000, 16'h0000, 16'hC000}},
    '{'{16'h0000, 16'h0000, 16'h4000, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
    '{'{16'h0000, 16'h0000, 16'hC000, 16'hFFFF, 16'h4000}, 1'b0, '0},
    '{'{16'h0000, 16'h0000, 16'h4000, 16'h8000, 16'h8000}, 1'b0, '0},
    '{'{16'h0000, 16'h0000, 16'h4000, 16'h4000, 16'hC000}, 1'b0, '0},
    // zero axis with a non-unit z
    '{'{16'h0000, 16'h0000, 16'h2000, 16'h1234, 16'h5678}, 1'b0, '0},
    '{'{16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h2000}, 1'b0, '0},
    '{'{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
    // horizontal normals along each axis
    '{'{16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{16'hC000, 16'h0000, 16'h0000, 16'hFFFF, 16'h3FFF}, 1'b0, '0},
    '{'{16'h0000, 16'h4000, 16'h0000, 16'h8000, 16'h7FFF}, 1'b0, '0},
    '{'{16'h0000, 16'hC000, 16'h0000, 16'h0001, 16'hBFFF}, 1'b0, '0},
    // tiny axis, near-parallel normalization
    '{'{16'h0001, 16'h0000, 16'h3FFF, 16'h9000, 16'h1000}, 1'b0, '0},
    '{'{16'h0000, 16'hFFFF, 16'hC001, 16'h7000, 16'hF000}, 1'b0, '0},
    // non-unit normals, over-range components drive saturation
    '{'{16'h4000, 16'h4000, 16'h4000, 16'h8000, 16'h6000}, 1'b0, '0},
    '{'{16'hC000, 16'hC000, 16'hC000, 16'hFFFF, 16'hE000}, 1'b0, '0},
    '{'{16'h4000, 16'hC000, 16'h0000, 16'h2000, 16'hA000}, 1'b0, '0},
    '{'{16'h2D41, 16'h0000, 16'h2D41, 16'h5555, 16'hAAAA}, 1'b0, '0},
    '{'{16'h1000, 16'hF000, 16'hD000, 16'hAAAA, 16'h5555}, 1'b0, '0},
    '{'{16'h0000, 16'h0000, 16'h4000, 16'h0001, 16'h0001}, 1'b0, '0}
  };

  initial begin
    sample_req_t q;
    int burst;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (directed[i]) send_sample(directed[i].req, directed[i].known, directed[i].dir);
    // hold off until the pipe has drained once
    in_valid_i <= 1'b0;
    wait (pending_dirs.size() == 0);
    @(negedge clk_i);
    for (int n = 0; n < NumRandom; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < NumRandom; k++, n++) begin
        q = rand_req();
        send_sample(q, 1'b0, '0);
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // ---------------------------------------------------------------- receiver

  // stall pattern: free-running stretches and stall-heavy windows in random order
  initial begin
    int phase_len;
    bit heavy;
    forever begin
      heavy = $urandom_range(0, 1);
      phase_len = $urandom_range(20, 120);
      repeat (phase_len) begin
        @(negedge clk_i);
        out_stall_i <= heavy ? ($urandom_range(0, 2) != 0) : 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    dir_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_dirs.size() == 0) begin
        $error("unexpected direction %h %h %h", dir_x_o, dir_y_o, dir_z_o);
        failures++;
      end else begin
        want = pending_dirs.pop_front();
        if (dir_x_o !== want.x) begin
          $error("dir_x expected %h actual %h", want.x, dir_x_o);
          failures++;
        end
        if (dir_y_o !== want.y) begin
          $error("dir_y expected %h actual %h", want.y, dir_y_o);
          failures++;
        end
        if (dir_z_o !== want.z) begin
          $error("dir_z expected %h actual %h", want.z, dir_z_o);
          failures++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- end of run

  initial begin
    wait (stim_done);
    wait (pending_dirs.size() == 0);
    // let anything stray fall out of the pipe
    repeat (Latency + 20) @(posedge clk_i);
    if (failures == 0 && pending_dirs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
